// ----- hdl/its_pkg.sv -----
// Package for the INI token scanner: token kinds, byte codes, result record.
package its_pkg;

    localparam int DEF_OFFSET_BITS = 24;
    localparam int FIELD_W         = 24;
    localparam int KIND_W          = 4;
    localparam int FLAGS_W         = 4;

    localparam logic [KIND_W-1:0] K_END     = 4'd0;
    localparam logic [KIND_W-1:0] K_INT     = 4'd1;
    localparam logic [KIND_W-1:0] K_STR     = 4'd2;
    localparam logic [KIND_W-1:0] K_SEC     = 4'd3;
    localparam logic [KIND_W-1:0] K_ASSIGN  = 4'd4;
    localparam logic [KIND_W-1:0] K_BLANK   = 4'd5;
    localparam logic [KIND_W-1:0] K_NEWLINE = 4'd6;
    localparam logic [KIND_W-1:0] K_BOOL    = 4'd7;
    localparam logic [KIND_W-1:0] K_IDENT   = 4'd8;

    localparam logic [FLAGS_W-1:0] ERR_UNTERM_STR = 4'b0001;
    localparam logic [FLAGS_W-1:0] ERR_EMPTY_SEC  = 4'b0010;
    localparam logic [FLAGS_W-1:0] ERR_STRAY_BRKT = 4'b0100;
    localparam logic [FLAGS_W-1:0] ERR_UNCLOSED   = 4'b1000;

    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_LBRKT   = 8'h5B;
    localparam logic [7:0] CH_RBRKT   = 8'h5D;
    localparam logic [7:0] CH_EQUALS  = 8'h3D;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_T       = 8'h74;
    localparam logic [7:0] CH_F       = 8'h66;

    localparam logic [2:0] LEN_TRUE  = 3'd4;
    localparam logic [2:0] LEN_FALSE = 3'd5;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [FIELD_W-1:0] span_begin;
        logic [FIELD_W-1:0] span_finish;
        logic [FIELD_W-1:0] value_begin;
        logic [FIELD_W-1:0] value_finish;
        logic               bool_is_true;
        logic [FLAGS_W-1:0] error_flags;
        logic               last_of_run;
    } token_t;

    function automatic logic is_blank(input logic [7:0] b);
        return (b == CH_SPACE) || (b == CH_TAB);
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= CH_ZERO) && (b <= CH_NINE);
    endfunction

    function automatic logic ends_ident(input logic [7:0] b);
        return (b == CH_NEWLINE) || is_blank(b) || (b == CH_EQUALS) || (b == CH_QUOTE);
    endfunction

    // Expected letter of "true" / "false" at a given match position.
    function automatic logic [7:0] keyword_letter(input logic is_true, input logic [2:0] idx);
        logic [7:0] ch;
        ch = 8'h00;
        if (is_true) begin
            case (idx[1:0])
                2'd0: ch = 8'h74;
                2'd1: ch = 8'h72;
                2'd2: ch = 8'h75;
                2'd3: ch = 8'h65;
                default: ch = 8'h00;
            endcase
        end else begin
            case (idx)
                3'd0: ch = 8'h66;
                3'd1: ch = 8'h61;
                3'd2: ch = 8'h6C;
                3'd3: ch = 8'h73;
                3'd4: ch = 8'h65;
                default: ch = 8'h00;
            endcase
        end
        return ch;
    endfunction

    function automatic token_t make_token(
        input logic [KIND_W-1:0]  kind,
        input logic [FIELD_W-1:0] sb,
        input logic [FIELD_W-1:0] sf,
        input logic [FIELD_W-1:0] vb,
        input logic [FIELD_W-1:0] vf,
        input logic               tru,
        input logic [FLAGS_W-1:0] flags
    );
        token_t t;
        t.kind         = kind;
        t.span_begin   = sb;
        t.span_finish  = sf;
        t.value_begin  = vb;
        t.value_finish = vf;
        t.bool_is_true = tru;
        t.error_flags  = flags;
        t.last_of_run  = 1'b0;
        return t;
    endfunction

endpackage

// ----- hdl/ini_token_scanner.sv -----
// INI token scanner: byte-wise lexer with a small result queue.
//
// Usage: feed the text one byte per item on the s_ channel (s_text_byte);
// an item with s_end_of_input set carries no byte and closes the text.
// Tokens leave on the m_ channel as offset spans with kind, value span,
// boolean value, error flags and last_of_run on the final token of an item.
// Each byte yields zero, one or two tokens; end of input yields the pending
// token, if any, and always the end token, then the scanner restarts at
// offset 0.
// A token is registered in the result queue when the item that causes it is
// accepted. The scanner takes one byte per cycle while s_ready is high; an item
// that makes two tokens leaves as two transfers on the single-token output port.
// s_ready is high while the 4-entry result queue has room for two tokens;
// it drops once more than two tokens wait, so a stalled receiver stops the
// input and no token is lost.
// Reset (aresetn low, synchronous) empties the queue and returns the scan
// state to idle at offset 0.
module ini_token_scanner import its_pkg::*; #(
    parameter int OFFSET_BITS = DEF_OFFSET_BITS
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_text_byte,
    input  logic               s_end_of_input,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [KIND_W-1:0]  m_token_kind,
    output logic [FIELD_W-1:0] m_span_begin,
    output logic [FIELD_W-1:0] m_span_finish,
    output logic [FIELD_W-1:0] m_value_begin,
    output logic [FIELD_W-1:0] m_value_finish,
    output logic               m_bool_is_true,
    output logic [FLAGS_W-1:0] m_error_flags,
    output logic               m_last_of_run
);

    typedef enum logic [2:0] {
        M_IDLE    = 3'd0,
        M_COMMENT = 3'd1,
        M_INT     = 3'd2,
        M_STR     = 3'd3,
        M_SEC     = 3'd4,
        M_KEYWORD = 3'd5,
        M_IDENT   = 3'd6
    } mode_t;

    typedef logic [OFFSET_BITS-1:0] off_t;

    mode_t      mode_reg,     mode_next;
    off_t       pos_reg,      pos_next;
    off_t       origin_reg,   origin_next;
    logic [2:0] kw_prog_reg,  kw_prog_next;
    logic       kw_true_reg,  kw_true_next;
    off_t       first_nb_reg, first_nb_next;
    off_t       end_nb_reg,   end_nb_next;
    logic       seen_nb_reg,  seen_nb_next;
    logic       stray_reg,    stray_next;

    token_t              queue_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W:0]     count_reg;

    logic       accept;
    logic       pop;
    logic [1:0] n_res;
    token_t     res0;
    token_t     res1;
    token_t     head;

    assign accept  = s_valid && s_ready;
    assign pop     = m_valid && m_ready;
    assign s_ready = (count_reg <= (QPTR_W+1)'(QUEUE_DEPTH - 2));
    assign m_valid = (count_reg != '0);

    // Scan logic: pending token closed by this byte, then the token the byte
    // starts (or the end token at end of input).
    always_comb begin
        logic [7:0]         b;
        off_t               p, p1, o, o1;
        logic [FIELD_W-1:0] fp, fp1, fo, fo1;
        logic               pend;
        token_t             pend_tok;
        logic               second;
        token_t             second_tok;
        logic               do_start;
        logic [2:0]         kw_len;
        logic [FLAGS_W-1:0] fl;

        b  = s_text_byte;
        p  = pos_reg;
        o  = origin_reg;
        p1 = p + OFFSET_BITS'(1);
        o1 = o + OFFSET_BITS'(1);
        fp  = FIELD_W'(p);
        fp1 = FIELD_W'(p1);
        fo  = FIELD_W'(o);
        fo1 = FIELD_W'(o1);

        pend       = 1'b0;
        pend_tok   = make_token(K_END, '0, '0, '0, '0, 1'b0, '0);
        second     = 1'b0;
        second_tok = make_token(K_END, '0, '0, '0, '0, 1'b0, '0);
        do_start   = 1'b0;
        kw_len     = kw_true_reg ? LEN_TRUE : LEN_FALSE;
        fl         = stray_reg ? ERR_STRAY_BRKT : '0;

        mode_next     = mode_reg;
        pos_next      = pos_reg;
        origin_next   = origin_reg;
        kw_prog_next  = kw_prog_reg;
        kw_true_next  = kw_true_reg;
        first_nb_next = first_nb_reg;
        end_nb_next   = end_nb_reg;
        seen_nb_next  = seen_nb_reg;
        stray_next    = stray_reg;

        if (s_end_of_input) begin
            case (mode_reg)
                M_INT: begin
                    pend = 1'b1;
                    pend_tok = make_token(K_INT, fo, fp, fo, fp, 1'b0, '0);
                end
                M_KEYWORD, M_IDENT: begin
                    pend = 1'b1;
                    pend_tok = make_token(K_IDENT, fo, fp, fo, fp, 1'b0, '0);
                end
                M_STR: begin
                    pend = 1'b1;
                    pend_tok = make_token(K_STR, fo, fp, fo1, fp, 1'b0, ERR_UNTERM_STR);
                end
                M_SEC: begin
                    pend = 1'b1;
                    pend_tok = make_token(K_SEC, fo, fp, fo1, fp, 1'b0, ERR_UNCLOSED | fl);
                end
                default: pend = 1'b0;
            endcase
            second = 1'b1;
            mode_next     = M_IDLE;
            pos_next      = '0;
            origin_next   = '0;
            kw_prog_next  = '0;
            kw_true_next  = 1'b0;
            first_nb_next = '0;
            end_nb_next   = '0;
            seen_nb_next  = 1'b0;
            stray_next    = 1'b0;
        end else begin
            pos_next = p1;
            case (mode_reg)
                M_COMMENT: begin
                    if (b == CH_NEWLINE) mode_next = M_IDLE;
                end
                M_INT: begin
                    if (!is_digit(b)) begin
                        pend = 1'b1;
                        pend_tok = make_token(K_INT, fo, fp, fo, fp, 1'b0, '0);
                        do_start = 1'b1;
                    end
                end
                M_STR: begin
                    if (b == CH_QUOTE) begin
                        pend = 1'b1;
                        pend_tok = make_token(K_STR, fo, fp1, fo1, fp, 1'b0, '0);
                        mode_next = M_IDLE;
                    end
                end
                M_SEC: begin
                    if (b == CH_RBRKT) begin
                        pend = 1'b1;
                        if (seen_nb_reg) begin
                            pend_tok = make_token(K_SEC, fo, fp1, FIELD_W'(first_nb_reg),
                                                  FIELD_W'(end_nb_reg), 1'b0, fl);
                        end else begin
                            pend_tok = make_token(K_SEC, fo, fp1, fo1, fo1, 1'b0,
                                                  fl | ERR_EMPTY_SEC);
                        end
                        mode_next = M_IDLE;
                    end else if (!is_blank(b)) begin
                        if (b == CH_LBRKT) stray_next = 1'b1;
                        if (!seen_nb_reg) first_nb_next = p;
                        end_nb_next  = p1;
                        seen_nb_next = 1'b1;
                    end
                end
                M_KEYWORD: begin
                    kw_prog_next = '0;
                    if (kw_prog_reg >= kw_len) begin
                        mode_next = M_IDENT;
                        if (ends_ident(b)) begin
                            pend = 1'b1;
                            pend_tok = make_token(K_IDENT, fo, fp, fo, fp, 1'b0, '0);
                            do_start = 1'b1;
                        end
                    end else if (b == keyword_letter(kw_true_reg, kw_prog_reg)) begin
                        if (kw_prog_reg + 3'd1 == kw_len) begin
                            pend = 1'b1;
                            pend_tok = make_token(K_BOOL, fo, fp1, fo, fp1, kw_true_reg, '0);
                            mode_next = M_IDLE;
                        end else begin
                            kw_prog_next = kw_prog_reg + 3'd1;
                        end
                    end else if (ends_ident(b)) begin
                        pend = 1'b1;
                        pend_tok = make_token(K_IDENT, fo, fp, fo, fp, 1'b0, '0);
                        do_start = 1'b1;
                    end else begin
                        mode_next = M_IDENT;
                    end
                end
                M_IDENT: begin
                    if (ends_ident(b)) begin
                        pend = 1'b1;
                        pend_tok = make_token(K_IDENT, fo, fp, fo, fp, 1'b0, '0);
                        do_start = 1'b1;
                    end
                end
                default: do_start = 1'b1;
            endcase

            // The byte opens a new token.
            if (do_start) begin
                origin_next = p;
                if (b == CH_SEMI) begin
                    mode_next = M_COMMENT;
                end else if (is_digit(b)) begin
                    mode_next = M_INT;
                end else if (b == CH_QUOTE) begin
                    mode_next = M_STR;
                end else if (b == CH_LBRKT) begin
                    mode_next     = M_SEC;
                    first_nb_next = '0;
                    end_nb_next   = '0;
                    seen_nb_next  = 1'b0;
                    stray_next    = 1'b0;
                end else if (b == CH_EQUALS) begin
                    mode_next  = M_IDLE;
                    second     = 1'b1;
                    second_tok = make_token(K_ASSIGN, fp, fp1, fp, fp1, 1'b0, '0);
                end else if (is_blank(b)) begin
                    mode_next  = M_IDLE;
                    second     = 1'b1;
                    second_tok = make_token(K_BLANK, fp, fp1, fp, fp1, 1'b0, '0);
                end else if (b == CH_NEWLINE) begin
                    mode_next  = M_IDLE;
                    second     = 1'b1;
                    second_tok = make_token(K_NEWLINE, fp, fp1, fp, fp1, 1'b0, '0);
                end else if ((b == CH_T) || (b == CH_F)) begin
                    mode_next    = M_KEYWORD;
                    kw_true_next = (b == CH_T);
                    kw_prog_next = 3'd1;
                end else begin
                    mode_next = M_IDENT;
                end
            end
        end

        // Pack results in emission order; last token of the item is flagged.
        pend_tok.last_of_run   = !second;
        second_tok.last_of_run = 1'b1;
        n_res = {1'b0, pend} + {1'b0, second};
        res0  = pend ? pend_tok : second_tok;
        res1  = second_tok;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= M_IDLE;
            pos_reg      <= '0;
            origin_reg   <= '0;
            kw_prog_reg  <= '0;
            kw_true_reg  <= 1'b0;
            first_nb_reg <= '0;
            end_nb_reg   <= '0;
            seen_nb_reg  <= 1'b0;
            stray_reg    <= 1'b0;
        end else if (accept) begin
            mode_reg     <= mode_next;
            pos_reg      <= pos_next;
            origin_reg   <= origin_next;
            kw_prog_reg  <= kw_prog_next;
            kw_true_reg  <= kw_true_next;
            first_nb_reg <= first_nb_next;
            end_nb_reg   <= end_nb_next;
            seen_nb_reg  <= seen_nb_next;
            stray_reg    <= stray_next;
        end
    end

    // Result queue: up to two writes per accepted item, one read per cycle while m_ready is high.
    always_ff @(posedge aclk) begin
        if (accept && (n_res != 2'd0)) begin
            queue_reg[wr_ptr_reg] <= res0;
            if (n_res == 2'd2) queue_reg[wr_ptr_reg + QPTR_W'(1)] <= res1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (accept) wr_ptr_reg <= wr_ptr_reg + QPTR_W'(n_res);
            if (pop) rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            count_reg <= count_reg + (accept ? (QPTR_W+1)'(n_res) : '0)
                                   - (pop ? (QPTR_W+1)'(1) : '0);
        end
    end

    assign head           = queue_reg[rd_ptr_reg];
    assign m_token_kind   = head.kind;
    assign m_span_begin   = head.span_begin;
    assign m_span_finish  = head.span_finish;
    assign m_value_begin  = head.value_begin;
    assign m_value_finish = head.value_finish;
    assign m_bool_is_true = head.bool_is_true;
    assign m_error_flags  = head.error_flags;
    assign m_last_of_run  = head.last_of_run;

endmodule

// ----- bench/tb.sv -----
// Testbench for ini_token_scanner: token predictor, scoreboard and stream drivers.
`timescale 1ns / 1ps

module tb import its_pkg::*; ();

    localparam int OFS_W        = DEF_OFFSET_BITS;
    localparam int RANDOM_ITEMS = 1000;
    localparam int QUIET_TAIL   = 150;
    localparam int DRAIN_CYCLES = 16;
    localparam int CYCLE_LIMIT  = 400000;

    localparam logic [FLAGS_W-1:0] NO_FLAGS = '0;

    typedef enum bit [2:0] {
        SM_IDLE, SM_COMMENT, SM_INT, SM_STR, SM_SEC, SM_KEYWORD, SM_IDENT
    } scan_mode_t;

    class token_scoreboard;
        scan_mode_t     mode;
        bit [OFS_W-1:0] pos, origin, first_nb, end_nb;
        bit [2:0]       kw_count;
        bit             kw_true, seen_nb, nonempty, stray;
        token_t         due[$];
        token_t         batch[$];
        int             errors;
        int             checked;

        function new();
            restart();
            errors  = 0;
            checked = 0;
        endfunction

        function void restart();
            mode     = SM_IDLE;
            pos      = '0;
            origin   = '0;
            kw_count = '0;
            kw_true  = 1'b0;
            first_nb = '0;
            end_nb   = '0;
            seen_nb  = 1'b0;
            nonempty = 1'b0;
            stray    = 1'b0;
        endfunction

        function bit spacing(bit [7:0] b);
            return b == CH_SPACE || b == CH_TAB;
        endfunction

        function bit numeral(bit [7:0] b);
            return b >= CH_ZERO && b <= CH_NINE;
        endfunction

        function bit breaks_word(bit [7:0] b);
            return b == CH_NEWLINE || spacing(b) || b == CH_EQUALS || b == CH_QUOTE;
        endfunction

        function bit [7:0] keyword_char(bit tru, bit [2:0] idx);
            string w;
            if (tru) begin
                w = "true";
                return w[idx[1:0]];
            end
            w = "false";
            return w[idx];
        endfunction

        function void queue_token(logic [KIND_W-1:0] kind, bit [OFS_W-1:0] sb,
                                  bit [OFS_W-1:0] sf, bit [OFS_W-1:0] vb,
                                  bit [OFS_W-1:0] vf, bit tru, logic [FLAGS_W-1:0] flags);
            token_t t;
            t.kind         = kind;
            t.span_begin   = sb;
            t.span_finish  = sf;
            t.value_begin  = vb;
            t.value_finish = vf;
            t.bool_is_true = tru;
            t.error_flags  = flags;
            t.last_of_run  = 1'b0;
            batch = {batch, t};
        endfunction

        // First byte of a new token; single-byte tokens come out right away.
        function void open_token(bit [7:0] b);
            bit [OFS_W-1:0] p1;
            p1 = pos + 1'b1;
            origin = pos;
            if (b == CH_SEMI) begin
                mode = SM_COMMENT;
            end else if (numeral(b)) begin
                mode = SM_INT;
            end else if (b == CH_QUOTE) begin
                mode = SM_STR;
            end else if (b == CH_LBRKT) begin
                mode     = SM_SEC;
                first_nb = '0;
                end_nb   = '0;
                seen_nb  = 1'b0;
                nonempty = 1'b0;
                stray    = 1'b0;
            end else if (b == CH_EQUALS) begin
                mode = SM_IDLE;
                queue_token(K_ASSIGN, pos, p1, pos, p1, 1'b0, NO_FLAGS);
            end else if (spacing(b)) begin
                mode = SM_IDLE;
                queue_token(K_BLANK, pos, p1, pos, p1, 1'b0, NO_FLAGS);
            end else if (b == CH_NEWLINE) begin
                mode = SM_IDLE;
                queue_token(K_NEWLINE, pos, p1, pos, p1, 1'b0, NO_FLAGS);
            end else if (b == CH_T || b == CH_F) begin
                mode     = SM_KEYWORD;
                kw_true  = (b == CH_T);
                kw_count = 3'd1;
            end else begin
                mode = SM_IDENT;
            end
        endfunction

        function void note_item(bit [7:0] b, bit eoi);
            bit [OFS_W-1:0]     p1, o1;
            logic [FLAGS_W-1:0] fl;
            bit [2:0]           word_len;
            batch.delete();
            p1 = pos + 1'b1;
            o1 = origin + 1'b1;
            if (eoi) begin
                case (mode)
                    SM_INT: queue_token(K_INT, origin, pos, origin, pos, 1'b0, NO_FLAGS);
                    SM_KEYWORD, SM_IDENT:
                        queue_token(K_IDENT, origin, pos, origin, pos, 1'b0, NO_FLAGS);
                    SM_STR: queue_token(K_STR, origin, pos, o1, pos, 1'b0, ERR_UNTERM_STR);
                    SM_SEC: begin
                        fl = ERR_UNCLOSED | (stray ? ERR_STRAY_BRKT : NO_FLAGS);
                        queue_token(K_SEC, origin, pos, o1, pos, 1'b0, fl);
                    end
                    default: ;
                endcase
                queue_token(K_END, '0, '0, '0, '0, 1'b0, NO_FLAGS);
                restart();
            end else begin
                case (mode)
                    SM_COMMENT: begin
                        if (b == CH_NEWLINE) mode = SM_IDLE;
                    end
                    SM_INT: begin
                        if (!numeral(b)) begin
                            queue_token(K_INT, origin, pos, origin, pos, 1'b0, NO_FLAGS);
                            open_token(b);
                        end
                    end
                    SM_STR: begin
                        if (b == CH_QUOTE) begin
                            queue_token(K_STR, origin, p1, o1, pos, 1'b0, NO_FLAGS);
                            mode = SM_IDLE;
                        end
                    end
                    SM_SEC: begin
                        if (b == CH_RBRKT) begin
                            fl = stray ? ERR_STRAY_BRKT : NO_FLAGS;
                            if (seen_nb)
                                queue_token(K_SEC, origin, p1, first_nb, end_nb, 1'b0, fl);
                            else
                                queue_token(K_SEC, origin, p1, o1, o1, 1'b0, fl | ERR_EMPTY_SEC);
                            mode = SM_IDLE;
                        end else if (spacing(b)) begin
                            nonempty = 1'b1;
                        end else begin
                            if (b == CH_LBRKT) stray = 1'b1;
                            if (!seen_nb) first_nb = pos;
                            end_nb   = p1;
                            seen_nb  = 1'b1;
                            nonempty = 1'b1;
                        end
                    end
                    SM_KEYWORD: begin
                        word_len = kw_true ? LEN_TRUE : LEN_FALSE;
                        if (kw_count >= word_len) begin
                            kw_count = '0;
                            mode     = SM_IDENT;
                            if (breaks_word(b)) begin
                                queue_token(K_IDENT, origin, pos, origin, pos, 1'b0, NO_FLAGS);
                                open_token(b);
                            end
                        end else if (b == keyword_char(kw_true, kw_count)) begin
                            kw_count++;
                            if (kw_count == word_len) begin
                                queue_token(K_BOOL, origin, p1, origin, p1, kw_true, NO_FLAGS);
                                kw_count = '0;
                                mode     = SM_IDLE;
                            end
                        end else begin
                            // partial keyword falls back to an identifier
                            kw_count = '0;
                            if (breaks_word(b)) begin
                                queue_token(K_IDENT, origin, pos, origin, pos, 1'b0, NO_FLAGS);
                                open_token(b);
                            end else begin
                                mode = SM_IDENT;
                            end
                        end
                    end
                    SM_IDENT: begin
                        if (breaks_word(b)) begin
                            queue_token(K_IDENT, origin, pos, origin, pos, 1'b0, NO_FLAGS);
                            open_token(b);
                        end
                    end
                    default: open_token(b);
                endcase
                pos = p1;
            end
            if (batch.size() > 0) batch[batch.size() - 1].last_of_run = 1'b1;
            due = {due, batch};
        endfunction

        task report(string msg);
            errors++;
            $display("[%0t] mismatch: %s", $time, msg);
        endtask

        task compare(string field, logic [31:0] got_v, logic [31:0] want_v);
            if (got_v !== want_v)
                report($sformatf("token %0d %s got %0h want %0h", checked, field, got_v, want_v));
        endtask

        task check_token(token_t got);
            token_t want;
            if (due.size() == 0) begin
                report($sformatf("token %0d kind %0d span %0h..%0h with none outstanding",
                                 checked, got.kind, got.span_begin, got.span_finish));
            end else begin
                want = due.pop_front();
                compare("token_kind", 32'(got.kind), 32'(want.kind));
                compare("span_begin", 32'(got.span_begin), 32'(want.span_begin));
                compare("span_finish", 32'(got.span_finish), 32'(want.span_finish));
                compare("value_begin", 32'(got.value_begin), 32'(want.value_begin));
                compare("value_finish", 32'(got.value_finish), 32'(want.value_finish));
                compare("bool_is_true", 32'(got.bool_is_true), 32'(want.bool_is_true));
                compare("error_flags", 32'(got.error_flags), 32'(want.error_flags));
                compare("last_of_run", 32'(got.last_of_run), 32'(want.last_of_run));
            end
            checked++;
        endtask
    endclass

    logic               aclk;
    logic               aresetn        = 1'b0;
    logic               s_valid        = 1'b0;
    logic [7:0]         s_text_byte    = 8'h00;
    logic               s_end_of_input = 1'b0;
    logic               m_ready        = 1'b0;
    logic               s_ready;
    logic               m_valid;
    logic [KIND_W-1:0]  m_token_kind;
    logic [FIELD_W-1:0] m_span_begin;
    logic [FIELD_W-1:0] m_span_finish;
    logic [FIELD_W-1:0] m_value_begin;
    logic [FIELD_W-1:0] m_value_finish;
    logic               m_bool_is_true;
    logic [FLAGS_W-1:0] m_error_flags;
    logic               m_last_of_run;

    token_scoreboard board = new();
    bit              bursts_on = 1'b1;
    int              sent = 0;
    int              rx_hold = 0;
    int              cycle_count = 0;

    ini_token_scanner u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_text_byte    (s_text_byte),
        .s_end_of_input (s_end_of_input),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_token_kind   (m_token_kind),
        .m_span_begin   (m_span_begin),
        .m_span_finish  (m_span_finish),
        .m_value_begin  (m_value_begin),
        .m_value_finish (m_value_finish),
        .m_bool_is_true (m_bool_is_true),
        .m_error_flags  (m_error_flags),
        .m_last_of_run  (m_last_of_run)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Called at a rising edge; returns at the edge where the item is taken.
    task automatic push_byte(input bit [7:0] b, input bit eoi);
        if (bursts_on && $urandom_range(0, 2) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_text_byte    <= b;
        s_end_of_input <= eoi;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        board.note_item(b, eoi);
        sent++;
    endtask

    task automatic push_text(input string txt);
        for (int i = 0; i < txt.len(); i++) push_byte(txt[i], 1'b0);
    endtask

    task automatic push_blanks(input int most);
        repeat ($urandom_range(0, most))
            push_byte($urandom_range(0, 1) ? CH_SPACE : CH_TAB, 1'b0);
    endtask

    task automatic push_digits();
        repeat ($urandom_range(1, 5)) push_byte(CH_ZERO + 8'($urandom_range(0, 9)), 1'b0);
    endtask

    task automatic push_word();
        string pool;
        pool = "abdeflnrstuxz_019AQ[];";
        case ($urandom_range(0, 7))
            0: push_text("true");
            1: push_text("false");
            2: push_text("tru");
            3: push_text("falsey");
            4: begin
                if ($urandom_range(0, 1)) push_text("trUe");
                else push_text("fa");
            end
            default: begin
                repeat ($urandom_range(1, 6))
                    push_byte(pool[$urandom_range(0, pool.len() - 1)], 1'b0);
            end
        endcase
    endtask

    task automatic push_value();
        bit [7:0] c;
        case ($urandom_range(0, 5))
            0: push_digits();
            1: begin
                push_digits();
                push_word();
            end
            2, 3: begin
                push_byte(CH_QUOTE, 1'b0);
                repeat ($urandom_range(0, 6)) begin
                    c = 8'($urandom_range(8'h20, 8'h7E));
                    push_byte(c == CH_QUOTE ? CH_SPACE : c, 1'b0);
                end
                if ($urandom_range(0, 9) != 0) push_byte(CH_QUOTE, 1'b0);
            end
            4: push_word();
            default: ;
        endcase
    endtask

    always @(posedge aclk) begin : rx_side
        token_t got;
        if (aresetn && m_valid && m_ready) begin
            got.kind         = m_token_kind;
            got.span_begin   = m_span_begin;
            got.span_finish  = m_span_finish;
            got.value_begin  = m_value_begin;
            got.value_finish = m_value_finish;
            got.bool_is_true = m_bool_is_true;
            got.error_flags  = m_error_flags;
            got.last_of_run  = m_last_of_run;
            board.check_token(got);
        end
        if (rx_hold > 0) begin
            rx_hold--;
            m_ready <= 1'b0;
        end else if (bursts_on && $urandom_range(0, 3) == 0) begin
            rx_hold = $urandom_range(0, 12);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("ini_token_scanner verification failed");
        $finish;
    end

    initial begin : stimulus
        int base;
        int quiet_from;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // trimmed section with stray bracket, assign, true, int split by newline,
        // closed string, comment cut by end of input
        push_text("[ a[\t]=true7\n\"q\";x");
        push_byte(8'hFF, 1'b1);
        // empty section, false, ident over 0xFF/0x00, unterminated string
        push_text("[ ]false");
        push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(CH_QUOTE, 1'b0);
        push_byte(8'h00, 1'b1);
        // unclosed section with stray bracket
        push_text("[[");
        push_byte(8'($urandom_range(0, 255)), 1'b1);

        base       = sent;
        quiet_from = base + RANDOM_ITEMS - QUIET_TAIL;
        while (sent < base + RANDOM_ITEMS) begin
            bursts_on = (sent < quiet_from) && ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(1, 6)) begin
                case ($urandom_range(0, 9))
                    0, 1: begin
                        push_byte(CH_LBRKT, 1'b0);
                        push_blanks(2);
                        if ($urandom_range(0, 4) != 0) push_word();
                        if ($urandom_range(0, 7) == 0) push_byte(CH_LBRKT, 1'b0);
                        if ($urandom_range(0, 9) == 0) push_byte(CH_NEWLINE, 1'b0);
                        push_blanks(2);
                        if ($urandom_range(0, 9) != 0) push_byte(CH_RBRKT, 1'b0);
                    end
                    2, 3, 4, 5: begin
                        push_blanks(1);
                        push_word();
                        push_blanks(2);
                        push_byte(CH_EQUALS, 1'b0);
                        push_blanks(2);
                        push_value();
                    end
                    6: begin
                        push_byte(CH_SEMI, 1'b0);
                        repeat ($urandom_range(0, 6))
                            push_byte(8'($urandom_range(0, 1) ? $urandom_range(8'h0B, 8'hFF)
                                                              : $urandom_range(8'h00, 8'h09)),
                                      1'b0);
                    end
                    7: push_blanks(3);
                    8: repeat ($urandom_range(1, 5)) push_byte(8'($urandom_range(0, 255)), 1'b0);
                    default: push_value();
                endcase
                if ($urandom_range(0, 7) != 0) push_byte(CH_NEWLINE, 1'b0);
            end
            // broken tail now and then
            case ($urandom_range(0, 7))
                0: push_byte(CH_LBRKT, 1'b0);
                1: push_byte(CH_QUOTE, 1'b0);
                2: push_word();
                3: push_digits();
                default: ;
            endcase
            push_byte(8'($urandom_range(0, 255)), 1'b1);
        end
        s_valid   <= 1'b0;
        bursts_on = 1'b0;

        while (board.due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (board.errors == 0 && board.due.size() == 0) begin
            $display("ini_token_scanner verification clean");
        end else begin
            $display("ini_token_scanner verification failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/its_pkg.sv
hdl/ini_token_scanner.sv
bench/tb.sv
